### hdl/skq_pkg.sv
`timescale 1ns / 1ps

package skq_pkg;

    // Number of cells in the chain
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [31:0] KEY_MIN = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_ONE = 32'h0000_0001;

    typedef enum logic [2:0] {
        OP_PREPEND = 3'd0,
        OP_APPEND  = 3'd1,
        OP_POP     = 3'd2,
        OP_INSERT  = 3'd3,
        OP_REMOVE  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Where a new entry goes
    typedef enum logic [1:0] {
        INS_PREPEND = 2'd0,
        INS_APPEND  = 2'd1,
        INS_SORTED  = 2'd2
    } ins_mode_t;

    // What every cell does this cycle
    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } cell_act_t;

    // Broadcast to all cells
    typedef struct packed {
        ins_mode_t          ins_mode;
        logic               rmv_by_key;
        logic signed [31:0] cmp_key;
        logic        [31:0] new_key;
        logic        [31:0] new_handle;
    } cell_cmd_t;

    // What a cell shows to its neighbors and to the top level
    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] handle;
        logic               valid;
        logic               ins;
        logic               rm;
        logic               hit;
    } cell_view_t;

endpackage

### hdl/skq_cell.sv
`timescale 1ns / 1ps

module skq_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  skq_pkg::cell_cmd_t    cmd,
    input  skq_pkg::cell_act_t    act,
    input  skq_pkg::cell_view_t   left,
    input  skq_pkg::cell_view_t   right,
    output skq_pkg::cell_view_t   view
);

    logic signed [31:0] key_reg, key_next;
    logic        [31:0] handle_reg, handle_next;
    logic               valid_reg, valid_next;
    logic               ins_own, rm_own, hit;

    // Insert marks are a thermometer: set from the insertion point to the end.
    always_comb begin
        case (cmd.ins_mode)
            skq_pkg::INS_PREPEND: ins_own = 1'b1;
            skq_pkg::INS_APPEND:  ins_own = !valid_reg;
            skq_pkg::INS_SORTED:  ins_own = !valid_reg || (key_reg > cmd.cmp_key);
            default:              ins_own = 1'b0;
        endcase
    end

    // Remove marks: from the removal point over the valid cells; pop marks all.
    assign rm_own = cmd.rmv_by_key ? (valid_reg && (key_reg >= cmd.cmp_key)) : 1'b1;
    assign hit    = rm_own && !left.rm && valid_reg
                    && (!cmd.rmv_by_key || (key_reg == cmd.cmp_key));

    always_comb begin
        key_next    = key_reg;
        handle_next = handle_reg;
        valid_next  = valid_reg;
        case (act)
            skq_pkg::ACT_INSERT: begin
                if (left.ins) begin
                    key_next    = left.key;
                    handle_next = left.handle;
                    valid_next  = left.valid;
                end else if (ins_own) begin
                    key_next    = cmd.new_key;
                    handle_next = cmd.new_handle;
                    valid_next  = 1'b1;
                end
            end
            skq_pkg::ACT_REMOVE: begin
                if (rm_own) begin
                    key_next    = right.key;
                    handle_next = right.handle;
                    valid_next  = right.valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign view = '{key: key_reg, handle: handle_reg, valid: valid_reg,
                    ins: ins_own, rm: rm_own, hit: hit};

endmodule

### hdl/sorted_key_queue_top.sv
`timescale 1ns / 1ps

// Sorted key queue: up to DEPTH (key, handle) entries held in ascending key
// order in a chain of cells, head in cell 0.
//
// Input channel s_*: one operation per transfer. s_tuser carries the opcode
// (prepend, append, pop head, sorted insert, sorted remove), s_tdata carries
// the key and the handle.
// Result channel m_*: exactly one result per operation, in order. m_tuser is
// the status (ok, empty, full and dropped, key not found), m_tdata the key and
// handle of the removed entry, zero when nothing was removed.
//
// The result is registered: m_tvalid rises in the cycle after the transfer.
// Throughput is one operation per cycle while the receiver keeps up: every
// cell compares its own key against the broadcast key and shifts toward its
// neighbor in the same cycle. The result sits in an output register; a new
// operation is taken whenever that register is empty or being drained, so a
// stalled receiver stalls the input after one pending result.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared, only their valid flags.
module sorted_key_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] in_key, [63:32] in_handle
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] out_key, [63:32] out_handle
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int DEPTH = skq_pkg::DEPTH;
    localparam int CNT_W = skq_pkg::CNT_W;

    skq_pkg::cell_view_t view [DEPTH];
    skq_pkg::cell_cmd_t  cmd;
    skq_pkg::cell_act_t  act;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [63:0]      m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg, m_tuser_next;

    logic             accept;
    logic             full, empty, found;
    logic [31:0]      tail_key, rm_key, rm_handle, head_key;
    logic [DEPTH-1:0] hit_vec, valid_vec;
    skq_pkg::opcode_t opcode;
    logic signed [31:0] in_key;
    logic [31:0]      in_handle;

    assign opcode    = skq_pkg::opcode_t'(s_tuser);
    assign in_key    = s_tdata[31:0];
    assign in_handle = s_tdata[63:32];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_key = view[0].key;

    // One-hot picks: tail cell and removed cell
    always_comb begin
        tail_key  = '0;
        rm_key    = '0;
        rm_handle = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_vec[i]   = view[i].hit;
            valid_vec[i] = view[i].valid;
            if (view[i].hit) begin
                rm_key    = rm_key | view[i].key;
                rm_handle = rm_handle | view[i].handle;
            end
            if (view[i].valid && ((i == DEPTH - 1) || !view[(i + 1) % DEPTH].valid)) begin
                tail_key = tail_key | view[i].key;
            end
        end
    end
    assign found = |hit_vec;

    // Broadcast command
    always_comb begin
        cmd.cmp_key    = in_key;
        cmd.new_handle = in_handle;
        cmd.rmv_by_key = (opcode == skq_pkg::OP_REMOVE);
        case (opcode)
            skq_pkg::OP_PREPEND: cmd.ins_mode = skq_pkg::INS_PREPEND;
            skq_pkg::OP_APPEND:  cmd.ins_mode = skq_pkg::INS_APPEND;
            default:             cmd.ins_mode = skq_pkg::INS_SORTED;
        endcase
        // Made-up keys saturate at the key range; an empty queue starts at 1
        if (empty && (opcode == skq_pkg::OP_PREPEND || opcode == skq_pkg::OP_APPEND)) begin
            cmd.new_key = skq_pkg::KEY_ONE;
        end else if (opcode == skq_pkg::OP_PREPEND) begin
            cmd.new_key = (head_key == skq_pkg::KEY_MIN) ? head_key : head_key - 32'd1;
        end else if (opcode == skq_pkg::OP_APPEND) begin
            cmd.new_key = (tail_key == skq_pkg::KEY_MAX) ? tail_key : tail_key + 32'd1;
        end else begin
            cmd.new_key = in_key;
        end
    end

    // Operation decode, status and result
    always_comb begin
        act           = skq_pkg::ACT_HOLD;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        count_next    = count_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = skq_pkg::ST_OK;
            m_tdata_next  = '0;
            case (opcode)
                skq_pkg::OP_PREPEND, skq_pkg::OP_APPEND, skq_pkg::OP_INSERT: begin
                    if (full) begin
                        m_tuser_next = skq_pkg::ST_FULL;
                    end else begin
                        act        = skq_pkg::ACT_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                skq_pkg::OP_POP, skq_pkg::OP_REMOVE: begin
                    if (empty) begin
                        m_tuser_next = skq_pkg::ST_EMPTY;
                    end else if (!found) begin
                        m_tuser_next = skq_pkg::ST_NOT_FOUND;
                    end else begin
                        act          = skq_pkg::ACT_REMOVE;
                        count_next   = count_reg - CNT_W'(1);
                        m_tdata_next = {rm_handle, rm_key};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        skq_pkg::cell_view_t left_v, right_v;
        if (i == 0) begin : g_head
            assign left_v = '{key: '0, handle: '0, valid: 1'b1, ins: 1'b0, rm: 1'b0,
                              hit: 1'b0};
        end else begin : g_mid_l
            assign left_v = view[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_v = '{key: '0, handle: '0, valid: 1'b0, ins: 1'b0, rm: 1'b0,
                               hit: 1'b0};
        end else begin : g_mid_r
            assign right_v = view[i+1];
        end
        skq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .act     (act),
            .left    (left_v),
            .right   (right_v),
            .view    (view[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_valid_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid flags disagree with entry count");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("more than one cell selected for removal");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");
`endif

endmodule
